>>> rtl/ors_pkg.sv
package ors_pkg;

   localparam int HISTORY_DEPTH = 8;

   localparam int TEMP_W   = 18;
   localparam int MEM_W    = 32;
   localparam int TIME_W   = 32;
   localparam int WIN_W    = 17;
   localparam int CONF_W   = 4;
   localparam int CNT_W    = 4;
   localparam int LEVEL_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WARN_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRIT_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRIT_CONF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MEM_LOW     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MEM_CONF    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STORM_WIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STORM_MAX   = 3'd6;

   // register reset values
   localparam logic [TEMP_W-1:0] RST_WARN_LIMIT = 18'd85000;
   localparam logic [TEMP_W-1:0] RST_CRIT_LIMIT = 18'd100000;
   localparam logic [CONF_W-1:0] RST_CRIT_CONF  = 4'd3;
   localparam logic [MEM_W-1:0]  RST_MEM_LOW    = 32'd102400;
   localparam logic [CONF_W-1:0] RST_MEM_CONF   = 4'd2;
   localparam logic [WIN_W-1:0]  RST_STORM_WIN  = 17'd3600;
   localparam logic [CNT_W-1:0]  RST_STORM_MAX  = 4'd2;

   // thermal level codes
   localparam logic [LEVEL_W-1:0] LVL_NONE     = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_NORMAL   = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_WARN     = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_COUNT    = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_REBOOT   = 3'd4;
   localparam logic [LEVEL_W-1:0] LVL_LOCKDOWN = 3'd5;

   typedef struct packed {
      logic              temp_valid;
      logic [TEMP_W-1:0] temp_milli;
      logic              mem_valid;
      logic [MEM_W-1:0]  free_kb;
      logic [TIME_W-1:0] now_sec;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] thermal_level;
      logic [CNT_W-1:0]   crit_run;
      logic [CNT_W-1:0]   recent_reboots;
      logic               mem_low;
      logic [CNT_W-1:0]   mem_run;
      logic               reclaim_request;
   } rsp_type;

   // token walking the stamp chain
   typedef struct packed {
      logic             go;
      logic [CNT_W-1:0] cnt;      // in-window stamps so far, saturates
      logic             found;    // a free slot has been claimed upstream
   } tok_type;

endpackage

>>> rtl/ors_cell.sv
module ors_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ors_pkg::TIME_W-1:0] now_sec,
   input  logic [ors_pkg::WIN_W-1:0]  window,
   input  logic                       commit,
   input  ors_pkg::tok_type           tok_in,
   output ors_pkg::tok_type           tok_out
);

   logic [ors_pkg::TIME_W-1:0] stamp_ff;
   logic                       valid_ff;
   logic                       cand_ff;
   ors_pkg::tok_type           tok_ff;

   logic [ors_pkg::TIME_W-1:0] age;
   logic                       in_win;
   logic [ors_pkg::CNT_W-1:0]  cnt_in;

   assign age    = now_sec - stamp_ff;
   assign in_win = valid_ff && (age < {{(ors_pkg::TIME_W-ors_pkg::WIN_W){1'b0}}, window});
   assign cnt_in = (in_win && tok_in.cnt != {ors_pkg::CNT_W{1'b1}})
                   ? tok_in.cnt + {{(ors_pkg::CNT_W-1){1'b0}}, 1'b1} : tok_in.cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         cand_ff    <= 1'b0;
         tok_ff.go  <= 1'b0;
      end else begin
         tok_ff.go <= tok_in.go;
         if (tok_in.go) begin
            valid_ff <= in_win;          // expired stamps drop out
            cand_ff  <= !in_win && !tok_in.found;
         end else if (commit && cand_ff) begin
            valid_ff <= 1'b1;
            cand_ff  <= 1'b0;
         end
      end
      tok_ff.cnt   <= cnt_in;
      tok_ff.found <= tok_in.found || !in_win;
      if (!tok_in.go && commit && cand_ff) begin
         stamp_ff <= now_sec;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> rtl/overheat_reboot_supervisor_unit.sv
// A sample that needs no reboot decision goes to the held result, then to the output register rsp.
// A reboot decision walks the stamp chain, one cell per cycle, before its result is held.
// No new sample is taken while a result is held inside or a decision walk is in progress.
// A waiting result does not block the next transfer; one more result can be held inside.
// Reset (synchronous, active high) loads register defaults, clears both counters,
// the last recent-reboot count and every stamp valid bit; stamps themselves are not reset.
module overheat_reboot_supervisor_unit #(
   parameter int HISTORY_DEPTH = ors_pkg::HISTORY_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ors_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ors_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [ors_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ors_pkg::CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // configuration registers
   logic [ors_pkg::TEMP_W-1:0] warn_limit_ff;
   logic [ors_pkg::TEMP_W-1:0] crit_limit_ff;
   logic [ors_pkg::CONF_W-1:0] crit_conf_ff;
   logic [ors_pkg::MEM_W-1:0]  mem_low_ff;
   logic [ors_pkg::CONF_W-1:0] mem_conf_ff;
   logic [ors_pkg::WIN_W-1:0]  storm_win_ff;
   logic [ors_pkg::CNT_W-1:0]  storm_max_ff;

   // block state
   state_type                  state_ff;
   logic [ors_pkg::CNT_W-1:0]  crit_cnt_ff;
   logic [ors_pkg::CNT_W-1:0]  mem_cnt_ff;
   logic [ors_pkg::CNT_W-1:0]  last_recent_ff;
   logic [ors_pkg::TIME_W-1:0] now_ff;
   ors_pkg::tok_type           head_ff;

   // result held inside, then the output register
   ors_pkg::rsp_type           pend_ff;
   logic                       pend_valid_ff;
   ors_pkg::rsp_type           rsp_ff;
   logic                       rsp_valid_ff;

   ors_pkg::tok_type           tok [HISTORY_DEPTH+1];
   ors_pkg::tok_type           tail;
   logic                       allow;
   logic                       commit;

   logic                       accept;
   logic                       hot;
   logic                       decide;
   logic [ors_pkg::CNT_W-1:0]  crit_inc;
   logic [ors_pkg::CNT_W-1:0]  crit_cnt_in;
   logic [ors_pkg::LEVEL_W-1:0] level_in;
   logic                       low;
   logic                       reclaim;
   logic [ors_pkg::CNT_W-1:0]  mem_inc;
   logic [ors_pkg::CNT_W-1:0]  mem_cnt_in;

   assign req_stall = (state_ff != ST_IDLE) || pend_valid_ff;
   assign accept    = req_valid && !req_stall;

   // thermal path: confirm count against the critical limit
   assign crit_inc = crit_cnt_ff + {{(ors_pkg::CNT_W-1){1'b0}}, 1'b1};
   assign hot      = req_data.temp_milli >= crit_limit_ff;
   assign decide   = req_data.temp_valid && hot && (crit_inc >= crit_conf_ff);

   always_comb begin
      if (!req_data.temp_valid) begin
         level_in    = ors_pkg::LVL_NONE;
         crit_cnt_in = crit_cnt_ff;
      end else if (hot) begin
         level_in    = decide ? ors_pkg::LVL_REBOOT : ors_pkg::LVL_COUNT;
         crit_cnt_in = decide ? '0 : crit_inc;
      end else begin
         level_in    = (req_data.temp_milli >= warn_limit_ff) ? ors_pkg::LVL_WARN
                                                              : ors_pkg::LVL_NORMAL;
         crit_cnt_in = '0;
      end
   end

   // memory path: one reclaim per confirmed low run
   assign mem_inc = mem_cnt_ff + {{(ors_pkg::CNT_W-1){1'b0}}, 1'b1};
   assign low     = req_data.mem_valid && (req_data.free_kb < mem_low_ff);
   assign reclaim = low && (mem_inc >= mem_conf_ff);

   always_comb begin
      if (!req_data.mem_valid) begin
         mem_cnt_in = mem_cnt_ff;
      end else if (low) begin
         mem_cnt_in = reclaim ? '0 : mem_inc;
      end else begin
         mem_cnt_in = '0;
      end
   end

   // stamp chain: the token enters at cell 0 and leaves the last cell with the
   // in-window count and whether a free slot was claimed on the way
   assign tok[0] = head_ff;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      ors_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .now_sec (now_ff),
         .window  (storm_win_ff),
         .commit  (commit),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign tail   = tok[HISTORY_DEPTH];
   assign allow  = tail.found && (tail.cnt < storm_max_ff);
   assign commit = tail.go && allow;   // claimed cell records the stamp

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_limit_ff  <= ors_pkg::RST_WARN_LIMIT;
         crit_limit_ff  <= ors_pkg::RST_CRIT_LIMIT;
         crit_conf_ff   <= ors_pkg::RST_CRIT_CONF;
         mem_low_ff     <= ors_pkg::RST_MEM_LOW;
         mem_conf_ff    <= ors_pkg::RST_MEM_CONF;
         storm_win_ff   <= ors_pkg::RST_STORM_WIN;
         storm_max_ff   <= ors_pkg::RST_STORM_MAX;
         state_ff       <= ST_IDLE;
         crit_cnt_ff    <= '0;
         mem_cnt_ff     <= '0;
         last_recent_ff <= '0;
         head_ff.go     <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ors_pkg::REG_WARN_LIMIT: warn_limit_ff <= csr_wdata[ors_pkg::TEMP_W-1:0];
               ors_pkg::REG_CRIT_LIMIT: crit_limit_ff <= csr_wdata[ors_pkg::TEMP_W-1:0];
               ors_pkg::REG_CRIT_CONF:  crit_conf_ff  <= csr_wdata[ors_pkg::CONF_W-1:0];
               ors_pkg::REG_MEM_LOW:    mem_low_ff    <= csr_wdata[ors_pkg::MEM_W-1:0];
               ors_pkg::REG_MEM_CONF:   mem_conf_ff   <= csr_wdata[ors_pkg::CONF_W-1:0];
               ors_pkg::REG_STORM_WIN:  storm_win_ff  <= csr_wdata[ors_pkg::WIN_W-1:0];
               ors_pkg::REG_STORM_MAX:  storm_max_ff  <= csr_wdata[ors_pkg::CNT_W-1:0];
               default: ;
            endcase
         end

         // one-cycle launch pulse; accept only happens in ST_IDLE
         head_ff.go <= accept && decide;

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  crit_cnt_ff <= crit_cnt_in;
                  mem_cnt_ff  <= mem_cnt_in;
                  if (decide) begin
                     state_ff   <= ST_WALK;
                  end else begin
                     pend_valid_ff <= 1'b1;
                  end
               end
            end
            ST_WALK: begin
               if (tail.go) begin
                  last_recent_ff <= tail.cnt;
                  pend_valid_ff  <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // hand the held result to the output register when it frees up
         if (pend_valid_ff && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // payload, no reset
      head_ff.cnt   <= '0;
      head_ff.found <= 1'b0;
      if (accept) begin
         now_ff                  <= req_data.now_sec;
         pend_ff.thermal_level   <= level_in;
         pend_ff.crit_run        <= crit_cnt_in;
         pend_ff.recent_reboots  <= last_recent_ff;
         pend_ff.mem_low         <= low;
         pend_ff.mem_run         <= mem_cnt_in;
         pend_ff.reclaim_request <= reclaim;
      end
      if (state_ff == ST_WALK && tail.go) begin
         pend_ff.thermal_level  <= allow ? ors_pkg::LVL_REBOOT : ors_pkg::LVL_LOCKDOWN;
         pend_ff.recent_reboots <= tail.cnt;
      end
      if (pend_valid_ff && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/sv/overheat_reboot_supervisor_unit_tb.sv
`timescale 1ns / 1ps

module overheat_reboot_supervisor_unit_tb;

   // index outside the register map: a write there must be dropped
   localparam logic [ors_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int PHASES          = 8;
   // block latency with a full stamp walk, plus margin
   localparam int SETTLE_CYCLES   = ors_pkg::HISTORY_DEPTH + 6;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   ors_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   ors_pkg::rsp_type               rsp_data;
   logic                           csr_we;
   logic [ors_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ors_pkg::CSR_DATA_W-1:0] csr_wdata;

   // directed rows may carry a hand-written expectation along with the transfer
   logic             probe_typed;
   ors_pkg::rsp_type probe_want;

   overheat_reboot_supervisor_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow of the supervisor: registers, counters and the stamp store
   // ------------------------------------------------------------------
   logic [ors_pkg::TEMP_W-1:0] sh_warn;
   logic [ors_pkg::TEMP_W-1:0] sh_crit;
   logic [ors_pkg::CONF_W-1:0] sh_crit_conf;
   logic [ors_pkg::MEM_W-1:0]  sh_mem_low;
   logic [ors_pkg::CONF_W-1:0] sh_mem_conf;
   logic [ors_pkg::WIN_W-1:0]  sh_window;
   logic [ors_pkg::CNT_W-1:0]  sh_storm_max;

   logic [ors_pkg::CNT_W-1:0]  heat_run;
   logic [ors_pkg::CNT_W-1:0]  starve_run;
   logic [ors_pkg::CNT_W-1:0]  last_recent;
   logic [ors_pkg::TIME_W-1:0] stamp_time [ors_pkg::HISTORY_DEPTH];
   logic                       stamp_live [ors_pkg::HISTORY_DEPTH];

   ors_pkg::rsp_type expected_reports [$];
   int unsigned fail_count;

   function automatic void shadow_reset();
      sh_warn      = ors_pkg::RST_WARN_LIMIT;
      sh_crit      = ors_pkg::RST_CRIT_LIMIT;
      sh_crit_conf = ors_pkg::RST_CRIT_CONF;
      sh_mem_low   = ors_pkg::RST_MEM_LOW;
      sh_mem_conf  = ors_pkg::RST_MEM_CONF;
      sh_window    = ors_pkg::RST_STORM_WIN;
      sh_storm_max = ors_pkg::RST_STORM_MAX;
      heat_run     = '0;
      starve_run   = '0;
      last_recent  = '0;
      for (int i = 0; i < ors_pkg::HISTORY_DEPTH; i++) begin
         stamp_time[i] = '0;
         stamp_live[i] = 1'b0;
      end
   endfunction

   // writes are cut to register width; unknown indexes fall through
   function automatic void shadow_csr_write(logic [ors_pkg::CSR_IDX_W-1:0] idx,
                                            logic [ors_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         ors_pkg::REG_WARN_LIMIT: sh_warn      = value[ors_pkg::TEMP_W-1:0];
         ors_pkg::REG_CRIT_LIMIT: sh_crit      = value[ors_pkg::TEMP_W-1:0];
         ors_pkg::REG_CRIT_CONF:  sh_crit_conf = value[ors_pkg::CONF_W-1:0];
         ors_pkg::REG_MEM_LOW:    sh_mem_low   = value[ors_pkg::MEM_W-1:0];
         ors_pkg::REG_MEM_CONF:   sh_mem_conf  = value[ors_pkg::CONF_W-1:0];
         ors_pkg::REG_STORM_WIN:  sh_window    = value[ors_pkg::WIN_W-1:0];
         ors_pkg::REG_STORM_MAX:  sh_storm_max = value[ors_pkg::CNT_W-1:0];
         default: ;
      endcase
   endfunction

   // Storm limiter: expire old (or future) stamps, count the rest, and claim
   // the first free slot when the window still has room.
   function automatic bit storm_admits(logic [ors_pkg::TIME_W-1:0] now);
      int unsigned                in_window;
      int                         free_slot;
      logic [ors_pkg::TIME_W-1:0] age;
      in_window = 0;
      free_slot = -1;
      for (int i = 0; i < ors_pkg::HISTORY_DEPTH; i++) begin
         if (stamp_live[i]) begin
            age = now - stamp_time[i];
            if (age < {15'd0, sh_window}) in_window++;
            else stamp_live[i] = 1'b0;
         end
         if (!stamp_live[i] && free_slot < 0) free_slot = i;
      end
      last_recent = (in_window > 15) ? 4'd15 : in_window[ors_pkg::CNT_W-1:0];
      if (in_window >= sh_storm_max || free_slot < 0) return 1'b0;
      stamp_time[free_slot] = now;
      stamp_live[free_slot] = 1'b1;
      return 1'b1;
   endfunction

   function automatic ors_pkg::rsp_type supervise_sample(ors_pkg::req_type s);
      ors_pkg::rsp_type r;
      r = '0;
      if (s.temp_valid) begin
         if (s.temp_milli >= sh_crit) begin
            heat_run = heat_run + 1'b1;
            // a confirm count of zero behaves like one
            if (heat_run >= sh_crit_conf) begin
               r.thermal_level = storm_admits(s.now_sec) ? ors_pkg::LVL_REBOOT
                                                         : ors_pkg::LVL_LOCKDOWN;
               heat_run = '0;
            end else begin
               r.thermal_level = ors_pkg::LVL_COUNT;
            end
         end else begin
            heat_run = '0;
            r.thermal_level = (s.temp_milli >= sh_warn) ? ors_pkg::LVL_WARN
                                                        : ors_pkg::LVL_NORMAL;
         end
      end
      if (s.mem_valid) begin
         if (s.free_kb < sh_mem_low) begin
            r.mem_low = 1'b1;
            starve_run = starve_run + 1'b1;
            if (starve_run >= sh_mem_conf) begin
               r.reclaim_request = 1'b1;
               starve_run = '0;
            end
         end else begin
            starve_run = '0;
         end
      end
      r.crit_run       = heat_run;
      r.recent_reboots = last_recent;
      r.mem_run        = starve_run;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard: check the result side first, then queue the prediction
   // for a request accepted on the same edge (its result is registered twice before it leaves).
   // ------------------------------------------------------------------
   task automatic note_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch on %s at %0t: expected %0d, got %0d", name, $time, want, got);
      end
   endtask

   always @(posedge clock) begin
      ors_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result transfer at %0t with no prediction pending", $time);
            end else begin
               want = expected_reports.pop_front();
               note_field("thermal_level",   32'(want.thermal_level),
                          32'(rsp_data.thermal_level));
               note_field("crit_run",        32'(want.crit_run),
                          32'(rsp_data.crit_run));
               note_field("recent_reboots",  32'(want.recent_reboots),
                          32'(rsp_data.recent_reboots));
               note_field("mem_low",         32'(want.mem_low),
                          32'(rsp_data.mem_low));
               note_field("mem_run",         32'(want.mem_run),
                          32'(rsp_data.mem_run));
               note_field("reclaim_request", 32'(want.reclaim_request),
                          32'(rsp_data.reclaim_request));
            end
         end
         if (req_valid && !req_stall) begin
            want = supervise_sample(req_data);
            // hand-written rows override; the shadow still advances
            expected_reports.push_back(probe_typed ? probe_want : want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Idle pattern: mostly short gaps, a few long ones, and quiet stretches
   // ------------------------------------------------------------------
   function automatic int unsigned pick_gap(ref int unsigned quiet_left, input int busy_pct);
      int unsigned roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 99) < 2) begin
         quiet_left = $urandom_range(20, 80);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < busy_pct) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   int unsigned rx_quiet;
   int unsigned rx_hold;

   // result side back-pressure, changes on the falling edge only
   always @(negedge clock) begin
      int unsigned g;
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_stall <= 1'b1;
      end else begin
         g = pick_gap(rx_quiet, 65);
         rx_hold = (g > 0) ? g - 1 : 0;
         rsp_stall <= (g > 0);
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   int unsigned tx_quiet;

   // Called at a falling edge; returns at the falling edge after the
   // transfer with valid still high, so back-to-back items need no toggle.
   task automatic send_sample(ors_pkg::req_type s, bit typed, ors_pkg::rsp_type want);
      req_valid   = 1'b1;
      req_data    = s;
      probe_typed = typed;
      probe_want  = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic sender_pause();
      int unsigned g;
      g = pick_gap(tx_quiet, 55);
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   // wait until every predicted result has been taken, then let the
   // block settle before touching registers
   task automatic drain_and_settle();
      req_valid = 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [ors_pkg::CSR_IDX_W-1:0] idx,
                            logic [ors_pkg::CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      shadow_csr_write(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_settings(logic [31:0] warn, logic [31:0] crit, logic [31:0] cconf,
                                logic [31:0] mlow, logic [31:0] mconf, logic [31:0] win,
                                logic [31:0] smax);
      csr_write(ors_pkg::REG_WARN_LIMIT, warn);
      csr_write(ors_pkg::REG_CRIT_LIMIT, crit);
      csr_write(ors_pkg::REG_CRIT_CONF,  cconf);
      csr_write(ors_pkg::REG_MEM_LOW,    mlow);
      csr_write(ors_pkg::REG_MEM_CONF,   mconf);
      csr_write(ors_pkg::REG_STORM_WIN,  win);
      csr_write(ors_pkg::REG_STORM_MAX,  smax);
   endtask

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   typedef struct {
      ors_pkg::req_type sample;
      bit               typed;
      ors_pkg::rsp_type want;
   } probe_row;

   probe_row probes [$];

   task automatic add_probe(int unsigned tv, int unsigned temp, int unsigned mv,
                            int unsigned free, int unsigned now, int unsigned typed,
                            logic [ors_pkg::LEVEL_W-1:0] lvl, int unsigned crun,
                            int unsigned recent, int unsigned low, int unsigned mrun,
                            int unsigned recl);
      probe_row row;
      row.sample.temp_valid     = tv[0];
      row.sample.temp_milli     = temp[ors_pkg::TEMP_W-1:0];
      row.sample.mem_valid      = mv[0];
      row.sample.free_kb        = free;
      row.sample.now_sec        = now;
      row.typed                 = typed[0];
      row.want.thermal_level    = lvl;
      row.want.crit_run         = crun[ors_pkg::CNT_W-1:0];
      row.want.recent_reboots   = recent[ors_pkg::CNT_W-1:0];
      row.want.mem_low          = low[0];
      row.want.mem_run          = mrun[ors_pkg::CNT_W-1:0];
      row.want.reclaim_request  = recl[0];
      probes.push_back(row);
   endtask

   // ------------------------------------------------------------------
   // Random samples: hot bursts long enough to reach a decision, low
   // memory bursts long enough for a reclaim, time mostly creeping
   // forward inside the window, with jumps, wraps and steps backward.
   // ------------------------------------------------------------------
   logic [ors_pkg::TIME_W-1:0] clock_sec;
   int unsigned                hot_left;
   int unsigned                starve_left;

   function automatic logic [ors_pkg::TEMP_W-1:0] hot_temp();
      int unsigned span;
      logic [31:0] pick;
      span = 32'h40000 - 32'(sh_crit);
      pick = 32'(sh_crit) + $urandom_range(0, span - 1);
      return pick[ors_pkg::TEMP_W-1:0];
   endfunction

   function automatic logic [ors_pkg::MEM_W-1:0] starved_kb();
      return (sh_mem_low == 0) ? '0 : $urandom_range(0, sh_mem_low - 1);
   endfunction

   function automatic ors_pkg::req_type draw_sample();
      ors_pkg::req_type s;
      int unsigned roll;
      logic [31:0] raw;

      s.temp_valid = ($urandom_range(0, 15) != 0);
      if (hot_left > 0) begin
         hot_left--;
         s.temp_milli = hot_temp();
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               hot_left     = 32'(sh_crit_conf);
               s.temp_milli = hot_temp();
               s.temp_valid = 1'b1;
            end
            1, 2: s.temp_milli = hot_temp();
            3:    s.temp_milli = sh_crit - 1'b1;
            4:    s.temp_milli = sh_warn;
            5:    s.temp_milli = sh_warn - 1'b1;
            6, 7: begin
               raw          = $urandom;
               s.temp_milli = raw[ors_pkg::TEMP_W-1:0];
            end
            8: begin
               raw          = $urandom_range(0, sh_warn);
               s.temp_milli = raw[ors_pkg::TEMP_W-1:0];
            end
            default: s.temp_milli = sh_crit;
         endcase
      end

      s.mem_valid = ($urandom_range(0, 15) != 0);
      if (starve_left > 0) begin
         starve_left--;
         s.free_kb = starved_kb();
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               starve_left = 32'(sh_mem_conf);
               s.free_kb   = starved_kb();
               s.mem_valid = 1'b1;
            end
            1, 2: s.free_kb = starved_kb();
            3:    s.free_kb = sh_mem_low;
            4:    s.free_kb = sh_mem_low - 1;
            5, 6: s.free_kb = $urandom;
            7:    s.free_kb = 32'hFFFF_FFFF;
            8:    s.free_kb = '0;
            default: s.free_kb = sh_mem_low + 1;
         endcase
      end

      roll = $urandom_range(0, 99);
      if (roll < 80)      clock_sec += $urandom_range(0, sh_window / 4 + 2);
      else if (roll < 90) clock_sec += $urandom_range(0, 2 * sh_window + 2);
      else if (roll < 95) clock_sec  = $urandom;
      else                clock_sec -= $urandom_range(1, 500);
      s.now_sec = clock_sec;
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      ors_pkg::rsp_type none;
      none = '0;

      req_valid   = 1'b0;
      req_data    = '0;
      probe_typed = 1'b0;
      probe_want  = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      fail_count  = 0;
      tx_quiet    = 0;
      rx_quiet    = 0;
      rx_hold     = 0;
      hot_left    = 0;
      starve_left = 0;
      shadow_reset();

      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults: warn 85000, crit 100000, confirm 3, 100 MiB, confirm 2,
      // window 3600 s, two reboots per window
      add_probe(0, 0,       0, 0,            0,    1, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 0,       1, 32'hFFFFFFFF, 0,    1, ors_pkg::LVL_NORMAL, 0, 0, 0, 0, 0);
      add_probe(1, 84999,   1, 102400,       5,    1, ors_pkg::LVL_NORMAL, 0, 0, 0, 0, 0);
      add_probe(1, 85000,   1, 102399,       5,    1, ors_pkg::LVL_WARN,   0, 0, 1, 1, 0);
      // unusable memory reading holds the low-memory run
      add_probe(1, 99999,   0, 0,            5,    1, ors_pkg::LVL_WARN,   0, 0, 0, 1, 0);
      add_probe(1, 32'h3FFFF, 1, 0,          10,   1, ors_pkg::LVL_COUNT,  1, 0, 1, 0, 1);
      // unusable temperature holds the critical run
      add_probe(0, 32'h3FFFF, 0, 0,          10,   1, ors_pkg::LVL_NONE,   1, 0, 0, 0, 0);
      add_probe(1, 100000,  1, 102400,       10,   1, ors_pkg::LVL_COUNT,  2, 0, 0, 0, 0);
      add_probe(1, 100000,  1, 0,            1000, 1, ors_pkg::LVL_REBOOT, 0, 0, 1, 1, 0);
      add_probe(1, 150000,  1, 0,            1500, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 99999,   1, 1,            1600, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 120000,  0, 0,            2000, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 120000,  0, 0,            2000, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 120000,  0, 0,            2000, 1, ors_pkg::LVL_REBOOT, 0, 1, 0, 1, 0);
      // third decision inside the window with two stamps held: lockdown
      add_probe(1, 130000,  0, 0,            3000, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 130000,  0, 0,            3000, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 130000,  0, 0,            3000, 1, ors_pkg::LVL_LOCKDOWN,
                0, 2, 0, 1, 0);
      // oldest stamp aged exactly one window: expired
      add_probe(1, 100000,  1, 5000,         4600, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 100000,  1, 5000,         4600, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 100000,  1, 5000,         4600, 0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      // time stepped backward: every stamp looks like it is from the future
      add_probe(1, 200000,  1, 200000,       100,  0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 200000,  1, 200000,       100,  0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 200000,  1, 200000,       100,  0, ors_pkg::LVL_NONE,   0, 0, 0, 0, 0);
      add_probe(1, 0,       1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, ors_pkg::LVL_NONE,
                0, 0, 0, 0, 0);

      foreach (probes[i]) begin
         sender_pause();
         send_sample(probes[i].sample, probes[i].typed, probes[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         // sender holds off until every result is back before each phase
         drain_and_settle();
         clock_sec = $urandom;
         case (p)
            0: begin
               load_settings(200000, 200000, 15, 32'hFFFF_FFFF, 15, 86400, 8);
               clock_sec = 32'hFFFF_C000;   // forces a wrap of the seconds counter
            end
            1: load_settings(0, 0, 1, 0, 1, 1, 0);
            2: begin
               // dropped write, then zero confirms (upper bits masked off)
               // and a window wide enough to fill the whole store
               csr_write(REG_UNUSED, $urandom);
               load_settings(90000, 95000, 32'hABCD_EF00, 50000, 32'h1234_5670,
                             32'hFFFF_FFFF, 15);
            end
            3: load_settings(120000, 80000, 2, 32'h8000_0000, 3, 600, 3);
            4: load_settings(32'(ors_pkg::RST_WARN_LIMIT), 32'(ors_pkg::RST_CRIT_LIMIT),
                             32'(ors_pkg::RST_CRIT_CONF), ors_pkg::RST_MEM_LOW,
                             32'(ors_pkg::RST_MEM_CONF), 32'(ors_pkg::RST_STORM_WIN),
                             32'(ors_pkg::RST_STORM_MAX));
            default: load_settings($urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
         endcase
         hot_left    = 0;
         starve_left = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sender_pause();
            send_sample(draw_sample(), 1'b0, none);
         end
      end

      drain_and_settle();
      if (fail_count == 0 && expected_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #12_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
